[sv/nmea_rmc_field_extractor_assert.svh]
// assertion macros for the nmea rmc field extractor
`ifndef NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH
`define NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// assertion on an explicit clock and active-low reset
`define NRFE_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assertion on the block clock and reset
`define NRFE_ASSERT(label, prop, msg) \
  `NRFE_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define NRFE_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define NRFE_ASSERT(label, prop, msg)
`endif

`endif

[sv/nrfe_pkg.sv]
// types, constants and helper functions of the nmea rmc field extractor
package nrfe_pkg;

  localparam logic [7:0] ASCII_LF    = 8'h0A;
  localparam logic [7:0] ASCII_COMMA = 8'h2C;
  localparam logic [7:0] ASCII_POINT = 8'h2E;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;
  localparam logic [7:0] ASCII_G     = 8'h47;
  localparam logic [7:0] ASCII_P     = 8'h50;
  localparam logic [7:0] ASCII_R     = 8'h52;
  localparam logic [7:0] ASCII_M     = 8'h4D;
  localparam logic [7:0] ASCII_C     = 8'h43;

  localparam logic [2:0] TAG_LEN = 3'd5;

  // field numbers within the sentence, the tag is field zero
  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_SPEED  = 4'd7;
  localparam logic [3:0] FLD_COURSE = 4'd8;
  localparam logic [3:0] FLD_LAST   = 4'd15;

  localparam logic [27:0] ACC_MAX    = 28'hFFFFFFF;
  localparam logic [27:0] TIME_MAX   = 28'h0FFFFFFF;
  localparam logic [27:0] STATUS_MAX = 28'h00000FF;
  localparam logic [27:0] LAT_MAX    = 28'h7FFFFFF;
  localparam logic [27:0] LON_MAX    = 28'hFFFFFFF;
  localparam logic [27:0] COURSE_MAX = 28'h007FFFF;
  // knots clamp so that knots * 1.852 just reaches the all-ones speed
  localparam logic [27:0] SPEED_CLAMP = 28'd1132371;
  localparam logic [31:0] SPEED_MUL   = 32'd1852;
  // ceil(2^41 / 1000), exact quotient for dividends below 2^31
  localparam logic [31:0] RECIP_1000  = 32'd2199023256;
  localparam int          RECIP_SHIFT = 41;

  typedef struct packed {
    logic       vld;
    logic       eol;
    logic       wr;
    logic [3:0] idx;
  } ctl_t;

  typedef struct packed {
    logic [18:0] course;
    logic [20:0] speed;
    logic [27:0] longitude;
    logic [26:0] latitude;
    logic [7:0]  fix_status;
    logic [27:0] utc_time;
  } res_t;

  function automatic logic [7:0] tag_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = ASCII_G;
      3'd1:    c = ASCII_P;
      3'd2:    c = ASCII_R;
      3'd3:    c = ASCII_M;
      3'd4:    c = ASCII_C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] frac_digits(input logic [3:0] idx);
    logic [2:0] fd;
    case (idx)
      FLD_LAT, FLD_LON:                fd = 3'd4;
      FLD_TIME, FLD_SPEED, FLD_COURSE: fd = 3'd3;
      default:                         fd = 3'd0;
    endcase
    return fd;
  endfunction

  function automatic logic field_used(input logic [3:0] idx);
    logic u;
    case (idx)
      FLD_TIME, FLD_STATUS, FLD_LAT, FLD_LON, FLD_SPEED, FLD_COURSE: u = 1'b1;
      default: u = 1'b0;
    endcase
    return u;
  endfunction

  function automatic logic [13:0] pow10(input logic [2:0] pad);
    logic [13:0] p;
    case (pad)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      default: p = 14'd10000;
    endcase
    return p;
  endfunction

  function automatic logic [27:0] field_max(input logic [3:0] idx);
    logic [27:0] m;
    case (idx)
      FLD_TIME:   m = TIME_MAX;
      FLD_STATUS: m = STATUS_MAX;
      FLD_LAT:    m = LAT_MAX;
      FLD_LON:    m = LON_MAX;
      FLD_SPEED:  m = SPEED_CLAMP;
      FLD_COURSE: m = COURSE_MAX;
      default:    m = ACC_MAX;
    endcase
    return m;
  endfunction

endpackage

[sv/nmea_rmc_field_extractor.sv]
// nmea rmc sentence field extractor, byte stream in, one fixed-point record per sentence out
//
// Takes one received character per cycle on the slave stream and hunts for the tag
// GPRMC. After the tag, commas advance a field counter (an empty field still counts)
// and the time, status, latitude, longitude, speed and course fields are converted
// from decimal text to fixed point: time, speed and course with three fraction digits,
// position with four; surplus fraction digits are dropped, missing ones padded with
// zeros, and every value saturates at the all-ones value of its result field. Speed
// is converted from knots to thousandths of km/h. A field that is absent or empty
// keeps the value from the previous sentence. At the newline byte one record goes
// out on the master stream once the final field has left the conversion pipe. Bytes
// are taken at one per cycle while the input is not held off; the per-byte parser
// updates its digit accumulator per byte, and each finished field runs through a
// five-stage pipe (power-of-ten scaling, saturation, two constant km/h multiplies).
// Up to two records may be in flight or waiting in the two-entry output buffer;
// while two are outstanding the input is held off until the master side takes one.
module nmea_rmc_field_extractor (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [7:0]   s_tdata_i,   // [7:0] rx_byte
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [135:0] m_tdata_o    // [27:0] utc_time, [35:28] fix_status,
                                    // [62:36] latitude, [90:63] longitude,
                                    // [111:91] speed_kmh, [130:112] course, rest zero
);
  import nrfe_pkg::*;

  `include "nmea_rmc_field_extractor_assert.svh"

  // parser state
  logic [2:0]  tag_pos_q, tag_pos_d;
  logic        in_sentence_q, in_sentence_d;
  logic [3:0]  field_idx_q, field_idx_d;
  logic [2:0]  frac_cnt_q, frac_cnt_d;
  logic        point_q, point_d;
  logic [27:0] accum_q, accum_d;
  logic        nonempty_q, nonempty_d;

  // conversion pipe
  ctl_t        p1_ctl_q, p1_ctl_d, p2_ctl_q, p3_ctl_q, p4_ctl_q, p5_ctl_q;
  logic [27:0] p1_acc_q, p1_acc_d;
  logic [2:0]  p1_frac_q, p1_frac_d;
  logic [41:0] p2_val_q, p2_val_d;
  logic [27:0] p3_val_q, p3_val_d;
  logic [31:0] p4_val_q, p4_val_d;
  logic [62:0] p5_val_q, p5_val_d;

  // held values
  res_t        held_q, held_d;

  // output buffer and outstanding record count
  res_t        fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  fifo_cnt_q, fifo_cnt_d;
  logic [1:0]  pend_q, pend_d;

  logic        in_xact, out_xact, eol_byte, push;
  logic [2:0]  tag_next, fd_cur, fd_p1, pad;
  logic [31:0] acc_times10;
  logic [27:0] p3_max;

  assign s_tready_o = (pend_q != 2'd2);
  assign in_xact    = s_tvalid_i && s_tready_o;
  assign out_xact   = m_tvalid_o && m_tready_i;
  assign eol_byte   = in_xact && in_sentence_q && (s_tdata_i == ASCII_LF);

  assign fd_cur      = frac_digits(field_idx_q);
  assign acc_times10 = ({4'd0, accum_q} << 3) + ({4'd0, accum_q} << 1)
                     + {28'd0, s_tdata_i[3:0]};
  assign tag_next    = (s_tdata_i == tag_char(tag_pos_q)) ? tag_pos_q + 3'd1 :
                       ((s_tdata_i == ASCII_G) ? 3'd1 : 3'd0);

  // per-byte parser: tag hunt, field counting, digit accumulation
  always_comb begin
    tag_pos_d     = tag_pos_q;
    in_sentence_d = in_sentence_q;
    field_idx_d   = field_idx_q;
    frac_cnt_d    = frac_cnt_q;
    point_d       = point_q;
    accum_d       = accum_q;
    nonempty_d    = nonempty_q;
    p1_ctl_d      = '0;
    p1_acc_d      = accum_q;
    p1_frac_d     = frac_cnt_q;
    if (in_xact) begin
      if (!in_sentence_q) begin
        tag_pos_d = tag_next;
        if (tag_next == TAG_LEN) begin
          tag_pos_d     = 3'd0;
          in_sentence_d = 1'b1;
          field_idx_d   = 4'd0;
          frac_cnt_d    = 3'd0;
          point_d       = 1'b0;
          accum_d       = '0;
          nonempty_d    = 1'b0;
        end
      end else if (s_tdata_i == ASCII_LF || s_tdata_i == ASCII_COMMA) begin
        // field done: hand it to the conversion pipe and clear
        p1_ctl_d.vld = 1'b1;
        p1_ctl_d.eol = (s_tdata_i == ASCII_LF);
        p1_ctl_d.wr  = nonempty_q && field_used(field_idx_q);
        p1_ctl_d.idx = field_idx_q;
        frac_cnt_d   = 3'd0;
        point_d      = 1'b0;
        accum_d      = '0;
        nonempty_d   = 1'b0;
        if (s_tdata_i == ASCII_LF) begin
          in_sentence_d = 1'b0;
          field_idx_d   = 4'd0;
          tag_pos_d     = 3'd0;
        end else if (field_idx_q != FLD_LAST) begin
          field_idx_d = field_idx_q + 4'd1;
        end
      end else begin
        nonempty_d = 1'b1;
        if (field_idx_q == FLD_STATUS) begin
          // status keeps its first character only
          if (!nonempty_q) accum_d = {20'd0, s_tdata_i};
        end else if (fd_cur != 3'd0) begin
          if (s_tdata_i >= ASCII_ZERO && s_tdata_i <= ASCII_NINE) begin
            if (!point_q || frac_cnt_q < fd_cur) begin
              accum_d = (acc_times10 > {4'd0, ACC_MAX}) ? ACC_MAX : acc_times10[27:0];
              if (point_q) frac_cnt_d = frac_cnt_q + 3'd1;
            end
          end else if (s_tdata_i == ASCII_POINT) begin
            point_d = 1'b1;
          end
        end
      end
    end
  end

  // stage 2: pad missing fraction digits by a power of ten
  assign fd_p1    = frac_digits(p1_ctl_q.idx);
  assign pad      = (p1_frac_q <= fd_p1) ? fd_p1 - p1_frac_q : 3'd0;
  assign p2_val_d = {14'd0, p1_acc_q} * {28'd0, pow10(pad)};

  // stage 3: saturate to the field range (speed to the km/h clamp)
  assign p3_max   = field_max(p2_ctl_q.idx);
  assign p3_val_d = (p2_val_q > {14'd0, p3_max}) ? p3_max : p2_val_q[27:0];

  // stage 4: knots times 1852
  assign p4_val_d = (p3_ctl_q.idx == FLD_SPEED) ? {11'd0, p3_val_q[20:0]} * SPEED_MUL
                                                : {4'd0, p3_val_q};

  // stage 5: divide by 1000 through the reciprocal
  assign p5_val_d = (p4_ctl_q.idx == FLD_SPEED) ? {32'd0, p4_val_q[30:0]} * {31'd0, RECIP_1000}
                                                : {31'd0, p4_val_q};

  // commit converted field into the held record
  always_comb begin
    held_d = held_q;
    if (p5_ctl_q.vld && p5_ctl_q.wr) begin
      case (p5_ctl_q.idx)
        FLD_TIME:   held_d.utc_time   = p5_val_q[27:0];
        FLD_STATUS: held_d.fix_status = p5_val_q[7:0];
        FLD_LAT:    held_d.latitude   = p5_val_q[26:0];
        FLD_LON:    held_d.longitude  = p5_val_q[27:0];
        FLD_SPEED:  held_d.speed      = p5_val_q[RECIP_SHIFT+20:RECIP_SHIFT];
        FLD_COURSE: held_d.course     = p5_val_q[18:0];
        default:    held_d = held_q;
      endcase
    end
  end

  assign push       = p5_ctl_q.vld && p5_ctl_q.eol;
  assign fifo_cnt_d = fifo_cnt_q + {1'b0, push} - {1'b0, out_xact};
  assign pend_d     = pend_q + {1'b0, eol_byte} - {1'b0, out_xact};

  assign m_tvalid_o = (fifo_cnt_q != 2'd0);
  assign m_tdata_o  = {5'd0, fifo_q[rd_ptr_q]};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_pos_q     <= '0;
      in_sentence_q <= 1'b0;
      field_idx_q   <= '0;
      frac_cnt_q    <= '0;
      point_q       <= 1'b0;
      accum_q       <= '0;
      nonempty_q    <= 1'b0;
      held_q        <= '0;
      p1_ctl_q      <= '0;
      p2_ctl_q      <= '0;
      p3_ctl_q      <= '0;
      p4_ctl_q      <= '0;
      p5_ctl_q      <= '0;
      wr_ptr_q      <= 1'b0;
      rd_ptr_q      <= 1'b0;
      fifo_cnt_q    <= '0;
      pend_q        <= '0;
    end else begin
      tag_pos_q     <= tag_pos_d;
      in_sentence_q <= in_sentence_d;
      field_idx_q   <= field_idx_d;
      frac_cnt_q    <= frac_cnt_d;
      point_q       <= point_d;
      accum_q       <= accum_d;
      nonempty_q    <= nonempty_d;
      held_q        <= held_d;
      p1_ctl_q      <= p1_ctl_d;
      p2_ctl_q      <= p1_ctl_q;
      p3_ctl_q      <= p2_ctl_q;
      p4_ctl_q      <= p3_ctl_q;
      p5_ctl_q      <= p4_ctl_q;
      fifo_cnt_q    <= fifo_cnt_d;
      pend_q        <= pend_d;
      if (push)     wr_ptr_q <= ~wr_ptr_q;
      if (out_xact) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p1_acc_q  <= p1_acc_d;
    p1_frac_q <= p1_frac_d;
    p2_val_q  <= p2_val_d;
    p3_val_q  <= p3_val_d;
    p4_val_q  <= p4_val_d;
    p5_val_q  <= p5_val_d;
    if (push) fifo_q[wr_ptr_q] <= held_d;
  end

  // buffered records never exceed the outstanding count
  `NRFE_ASSERT(a_fifo_within_pend, fifo_cnt_q <= pend_q, "output buffer exceeds outstanding count")
  // a newline inside a sentence always launches an end-of-line commit
  `NRFE_ASSERT(a_eol_launch, eol_byte |=> (p1_ctl_q.vld && p1_ctl_q.eol), "newline commit lost")
  // the km/h quotient always fits the speed field
  `NRFE_ASSERT(a_speed_fits, (p5_ctl_q.vld && p5_ctl_q.idx == FLD_SPEED) |-> (p5_val_q[62] == 1'b0), "speed quotient overflow")
  // a waiting record implies one outstanding
  `NRFE_ASSERT(a_valid_pend, m_tvalid_o |-> (pend_q != 2'd0), "record shown without outstanding count")

endmodule
